FILE: design/spq_pkg.sv
// shared types and codes for the stable priority queue
// no dependencies; used by spq_cell and stable_priority_queue_unit
package spq_pkg;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // valid priority range
    localparam logic [1:0] PRI_LOW  = 2'd1;
    localparam logic [1:0] PRI_HIGH = 2'd3;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADPRI = 3'd4
    } status_t;

    // broadcast command to every cell of the row
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [1:0] pri;
    } cell_cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic       valid;
        logic       gt;
        logic [1:0] pri;
    } cell_link_t;

endpackage

FILE: design/spq_cell.sv
// one slot of the sorted row: holds an entry, shifts towards the tail on insert
// and towards the head on removal; depends on spq_pkg
module spq_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_pkg::cell_cmd_t    cmd,
    input  logic [ID_BITS-1:0]    new_id,
    input  spq_pkg::cell_link_t   prev_link,
    input  logic [ID_BITS-1:0]    prev_id,
    input  spq_pkg::cell_link_t   next_link,
    input  logic [ID_BITS-1:0]    next_id,
    output spq_pkg::cell_link_t   link,
    output logic [ID_BITS-1:0]    id,
    output logic                  match
);

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic [1:0]         pri_reg;
    logic [1:0]         pri_next;
    logic               gt;

    // the new entry goes in front of this one
    assign gt    = valid_reg && (pri_reg > cmd.pri);
    assign match = valid_reg && (id_reg == new_id);

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.pri   = pri_reg;
    assign id         = id_reg;

    // next slot contents
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        pri_next   = pri_reg;
        if (cmd.enq)
        begin
            if (prev_link.gt)
            begin
                valid_next = prev_link.valid;
                id_next    = prev_id;
                pri_next   = prev_link.pri;
            end
            else if ((gt || !valid_reg) && prev_link.valid)
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                pri_next   = cmd.pri;
            end
        end
        else if (cmd.deq)
        begin
            valid_next = next_link.valid;
            id_next    = next_id;
            pri_next   = next_link.pri;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

endmodule

FILE: design/stable_priority_queue_unit.sv
// top level of the stable priority queue: a row of spq_cell slots kept sorted
// by priority then arrival, plus status logic and the result register; uses spq_pkg
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready operation entry_id      | into block
//          | entry_priority                            |
//  out     | out_valid out_ready status served_id      | out of block
//          | served_priority occupancy                 |
//
// one item per cycle: every slot compares with the broadcast item and takes its
// own, its neighbour's or the new entry in the same cycle it is accepted.
// the result is registered on acceptance and appears in the output register in the cycle after.
// in_ready drops only while a finished result waits for out_ready.
// reset empties the row at once (slot valid flags and count); no clearing pass.
module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [ID_BITS-1:0]                 entry_id,
    input  logic [1:0]                         entry_priority,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic [ID_BITS-1:0]                 served_id,
    output logic [1:0]                         served_priority,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    spq_pkg::cell_link_t  links [QUEUE_DEPTH+2];
    logic [ID_BITS-1:0]   ids   [QUEUE_DEPTH+2];
    logic [QUEUE_DEPTH-1:0] id_hits;
    spq_pkg::cell_cmd_t   cmd;

    logic                 accept;
    logic                 bad_pri;
    logic                 dup;
    logic                 full;
    logic                 empty;
    spq_pkg::status_t     status_c;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    spq_pkg::status_t     status_reg;
    logic [ID_BITS-1:0]   served_id_reg;
    logic [1:0]           served_pri_reg;
    logic [CNT_W-1:0]     occupancy_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // row ends: a head that never displaces, a tail that is always empty
    assign links[0].valid           = 1'b1;
    assign links[0].gt              = 1'b0;
    assign links[0].pri             = 2'd0;
    assign ids[0]                   = '0;
    assign links[QUEUE_DEPTH+1].valid = 1'b0;
    assign links[QUEUE_DEPTH+1].gt    = 1'b0;
    assign links[QUEUE_DEPTH+1].pri   = 2'd0;
    assign ids[QUEUE_DEPTH+1]         = '0;

    // row of slots, front at slot 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        spq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .new_id    (entry_id),
            .prev_link (links[g]),
            .prev_id   (ids[g]),
            .next_link (links[g+2]),
            .next_id   (ids[g+2]),
            .link      (links[g+1]),
            .id        (ids[g+1]),
            .match     (id_hits[g])
        );
    end

    // rejection checks
    assign bad_pri = (entry_priority < spq_pkg::PRI_LOW) ||
                     (entry_priority > spq_pkg::PRI_HIGH);
    assign dup     = |id_hits;
    assign full    = links[QUEUE_DEPTH].valid;
    assign empty   = !links[1].valid;

    // status and command for the row
    always_comb
    begin
        cmd.pri    = entry_priority;
        cmd.enq    = 1'b0;
        cmd.deq    = 1'b0;
        status_c   = spq_pkg::ST_OK;
        count_next = count_reg;
        if (operation == spq_pkg::OP_ENQ)
        begin
            if (bad_pri)
                status_c = spq_pkg::ST_BADPRI;
            else if (dup)
                status_c = spq_pkg::ST_DUP;
            else if (full)
                status_c = spq_pkg::ST_FULL;
            else
            begin
                cmd.enq    = accept;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
                status_c = spq_pkg::ST_EMPTY;
            else
            begin
                cmd.deq    = accept;
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // entry count and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_c;
            occupancy_reg <= count_next;
            if (operation == spq_pkg::OP_DEQ && !empty)
            begin
                served_id_reg  <= ids[1];
                served_pri_reg <= links[1].pri;
            end
            else
            begin
                served_id_reg  <= '0;
                served_pri_reg <= 2'd0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign served_id       = served_id_reg;
    assign served_priority = served_pri_reg;
    assign occupancy       = occupancy_reg;

    // count agrees with the front slot
    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == !links[1].valid)
        else $error("count and front slot disagree");

    // count agrees with the tail slot
    a_full_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_COUNT) == links[QUEUE_DEPTH].valid)
        else $error("count and tail slot disagree");

    // at most one slot holds the offered entry id
    a_unique_ids: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(id_hits))
        else $error("same id held in two slots");

    // an accepted removal shrinks the count by one
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.deq) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not shrink the count");

endmodule

FILE: sim/tb_top.sv
// self-checking bench for stable_priority_queue_unit: driver, result checker and
// a behavioural copy of the sorted queue; depends on spq_pkg and the block itself
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD  = 80;
    localparam int HALF_PHASE = 181;

    typedef struct {
        logic        op;
        logic [15:0] id;
        logic [1:0]  pri;
    } queue_op_t;

    typedef struct {
        spq_pkg::status_t status;
        logic [15:0]      id;
        logic [1:0]       pri;
        logic [4:0]       occ;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = spq_pkg::OP_ENQ;
    logic [15:0] entry_id = '0;
    logic [1:0]  entry_priority = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [1:0]  served_priority;
    logic [4:0]  occupancy;

    // pending stimulus and outstanding expectations
    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];

    // behavioural copy of the sorted row
    logic [15:0] slot_id[SLOTS];
    logic [1:0]  slot_pri[SLOTS];
    int          held = 0;
    int          peak_held = 0;

    // idling controls, set per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // bookkeeping
    int mismatches = 0;
    int enqueues = 0;
    int dequeues = 0;
    int status_seen[5] = '{default: 0};
    int quiet_cycles = 0;

    stable_priority_queue_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .entry_id       (entry_id),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .served_id      (served_id),
        .served_priority(served_priority),
        .occupancy      (occupancy)
    );

    // clock and a single reset at the start
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // apply one operation to the sorted row and give the result it produces
    function automatic queue_result_t serve_op(queue_op_t op);
        queue_result_t r;
        int            i;
        int            pos;
        bit            dup;
        r.status = spq_pkg::ST_OK;
        r.id     = '0;
        r.pri    = '0;
        if (op.op == spq_pkg::OP_ENQ)
        begin
            enqueues++;
            dup = 1'b0;
            for (i = 0; i < held; i++)
            begin
                if (slot_id[i] == op.id)
                    dup = 1'b1;
            end
            if (op.pri < spq_pkg::PRI_LOW || op.pri > spq_pkg::PRI_HIGH)
                r.status = spq_pkg::ST_BADPRI;
            else if (dup)
                r.status = spq_pkg::ST_DUP;
            else if (held >= SLOTS)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                // new entry goes behind every entry of equal or better priority
                pos = 0;
                while (pos < held && slot_pri[pos] <= op.pri)
                    pos++;
                for (i = held; i > pos; i--)
                begin
                    slot_id[i]  = slot_id[i-1];
                    slot_pri[i] = slot_pri[i-1];
                end
                slot_id[pos]  = op.id;
                slot_pri[pos] = op.pri;
                held++;
            end
        end
        else
        begin
            dequeues++;
            if (held == 0)
                r.status = spq_pkg::ST_EMPTY;
            else
            begin
                r.id  = slot_id[0];
                r.pri = slot_pri[0];
                for (i = 1; i < held; i++)
                begin
                    slot_id[i-1]  = slot_id[i];
                    slot_pri[i-1] = slot_pri[i];
                end
                held--;
            end
        end
        if (held > peak_held)
            peak_held = held;
        r.occ = 5'(held);
        return r;
    endfunction

    // report one field that differs from its expectation
    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, field, want, want, got, got);
        end
    endfunction

    // driver: predict on acceptance, then offer the next pending item
    always @(posedge clk)
    begin
        queue_op_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(serve_op('{operation, entry_id, entry_priority}));
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_ops.pop_front();
                    in_valid       <= 1'b1;
                    operation      <= nxt.op;
                    entry_id       <= nxt.id;
                    entry_priority <= nxt.pri;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result, then decide out_ready for the next cycle
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no item outstanding, expected none, %s",
                             $time, $sformatf("got status %0d id 0x%0h", status, served_id));
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("served_id", want.id, served_id);
                    compare_field("served_priority", want.pri, served_priority);
                    compare_field("occupancy", want.occ, occupancy);
                    status_seen[int'(want.status)]++;
                end
            end
            // a requested long hold-off takes precedence over random stalls
            if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= LONG_HOLD;
                out_ready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_op(logic op, logic [15:0] id, logic [1:0] pri);
        pending_ops.push_back('{op, id, pri});
    endtask

    // random bursts: fill-heavy, drain-heavy or balanced, ids often from a small pool
    task automatic queue_random(int n);
        int        left;
        int        burst;
        int        mode;
        int        roll;
        queue_op_t op;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(40, 12);
            if (burst > left)
                burst = left;
            mode = $urandom_range(2);
            repeat (burst)
            begin
                roll = $urandom_range(99);
                case (mode)
                    0: op.op = (roll < 75) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
                    1: op.op = (roll < 25) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
                    default: op.op = (roll < 50) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
                endcase
                roll = $urandom_range(99);
                if (roll < 50)
                    op.id = 16'($urandom_range(23));
                else if (roll < 60)
                    op.id = 16'hFFFF - 16'($urandom_range(15));
                else
                    op.id = 16'($urandom);
                op.pri = ($urandom_range(99) < 6) ? 2'd0 : 2'($urandom_range(3, 1));
                pending_ops.push_back(op);
            end
            left -= burst;
        end
    endtask

    // sender holds back until every outstanding result has been checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // phases: no idling, sender idle, receiver stalling, both
    initial
    begin
        int send_idle[4];
        int recv_stall[4];
        int k;
        send_idle  = '{0, 60, 0, 26};
        recv_stall = '{0, 0, 60, 26};
        @(posedge rst_n);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_idle[phase];
            recv_stall_pct = recv_stall[phase];
            if (phase == 0)
            begin
                // empty queue, id zero, top id, duplicates and bad priorities
                push_op(spq_pkg::OP_DEQ, 16'h1234, 2'd2);
                push_op(spq_pkg::OP_ENQ, 16'h0000, 2'd1);
                push_op(spq_pkg::OP_ENQ, 16'hFFFF, 2'd3);
                push_op(spq_pkg::OP_ENQ, 16'h0000, 2'd2);
                push_op(spq_pkg::OP_ENQ, 16'h0005, 2'd0);
                push_op(spq_pkg::OP_ENQ, 16'h0000, 2'd0);
                // ties queue behind earlier arrivals
                push_op(spq_pkg::OP_ENQ, 16'h0007, 2'd3);
                push_op(spq_pkg::OP_ENQ, 16'h0008, 2'd1);
                for (k = 0; k < 12; k++)
                    push_op(spq_pkg::OP_ENQ, 16'h0100 + 16'(k), 2'((k % 3) + 1));
                // rejections on a full queue, in their order of precedence
                push_op(spq_pkg::OP_ENQ, 16'h0200, 2'd2);
                push_op(spq_pkg::OP_ENQ, 16'h0007, 2'd1);
                push_op(spq_pkg::OP_ENQ, 16'h0300, 2'd0);
                push_op(spq_pkg::OP_DEQ, 16'hABCD, 2'd0);
                push_op(spq_pkg::OP_DEQ, 16'h5432, 2'd3);
            end
            queue_random(HALF_PHASE);
            if (phase == 0 || phase == 2)
                hold_requests++;
            wait_drained();
            queue_random(HALF_PHASE);
            wait_drained();
        end
        repeat (4) @(posedge clk);

        $display("covered %0d enqueues and %0d dequeues across four idling phases, %s",
                 enqueues, dequeues, $sformatf("peak occupancy %0d", peak_held));
        $display("outcomes: ok %0d, duplicate %0d, full %0d, empty %0d, bad priority %0d",
                 status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_DUP],
                 status_seen[spq_pkg::ST_FULL], status_seen[spq_pkg::ST_EMPTY],
                 status_seen[spq_pkg::ST_BADPRI]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
